### rtl/imm_pkg.sv
// ----------------------------------------------------------------------------
// imm_pkg
// Shared types and constants of the integer matrix multiplier: field widths,
// action and register codes, controller states and the command and status
// structs between controller and datapath.
// ----------------------------------------------------------------------------
package imm_pkg;

	localparam int DATA_W    = 32;
	localparam int IDX_W     = 3;
	localparam int DIM_W     = 4;
	localparam int ACT_W     = 2;
	localparam int CFG_IDX_W = 2;

	localparam logic [ACT_W-1:0] ACT_WR_A = 2'd0;
	localparam logic [ACT_W-1:0] ACT_WR_B = 2'd1;
	localparam logic [ACT_W-1:0] ACT_MUL  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_A_ROWS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_A_COLS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_B_ROWS = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_B_COLS = 2'd3;

	localparam logic [DIM_W-1:0] DIM_RESET = 4'd1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MISM,
		S_ISSUE,
		S_WAIT,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic             wr_a;
		logic             wr_b;
		logic             rd_en;
		logic             clr_acc;
		logic             emit;
		logic             emit_mis;
		logic             last;
		logic [IDX_W-1:0] row_idx;
		logic [IDX_W-1:0] col_idx;
		logic [IDX_W-1:0] k_idx;
	} imm_cmd_t;

	typedef struct packed {
		logic [DIM_W-1:0] a_rows;
		logic [DIM_W-1:0] a_cols;
		logic [DIM_W-1:0] b_rows;
		logic [DIM_W-1:0] b_cols;
		logic             pipe_busy;
	} imm_sts_t;

endpackage

### rtl/imm_ctrl.sv
// ----------------------------------------------------------------------------
// imm_ctrl
// Controller of the matrix multiplier: accepts commands, walks columns of B
// (outer) and rows of A (inner), issues one multiply-accumulate per cycle
// in the issue state and orders the datapath to emit each product element.
// ----------------------------------------------------------------------------
module imm_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [imm_pkg::ACT_W-1:0] action,
	input  imm_pkg::imm_sts_t         sts,
	output imm_pkg::imm_cmd_t         cmd,
	output logic                      busy
);
	import imm_pkg::*;

	state_t           state_q, state_d;
	logic [IDX_W-1:0] i_q, j_q, k_q;
	logic             accept;
	logic             k_last, j_last, i_last, elem_last;

	assign busy      = (state_q != S_IDLE);
	assign accept    = start && !busy;
	assign k_last    = ((DIM_W'(k_q) + 1'b1) == sts.a_cols);
	assign j_last    = ((DIM_W'(j_q) + 1'b1) == sts.a_rows);
	assign i_last    = ((DIM_W'(i_q) + 1'b1) == sts.b_cols);
	assign elem_last = j_last && i_last;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && action == ACT_MUL) begin
					if (sts.a_cols != sts.b_rows)
						state_d = S_MISM;
					else if (sts.a_rows == '0 || sts.b_cols == '0)
						state_d = S_IDLE;
					else if (sts.a_cols == '0)
						state_d = S_WAIT;
					else
						state_d = S_ISSUE;
				end
			end
			S_MISM: state_d = S_IDLE;
			S_ISSUE: begin
				if (k_last)
					state_d = S_WAIT;
			end
			S_WAIT: begin
				if (!sts.pipe_busy)
					state_d = S_EMIT;
			end
			S_EMIT: begin
				if (elem_last)
					state_d = S_IDLE;
				else if (sts.a_cols == '0)
					state_d = S_WAIT;
				else
					state_d = S_ISSUE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd         = '0;
		cmd.row_idx = j_q;
		cmd.col_idx = i_q;
		cmd.k_idx   = k_q;
		case (state_q)
			S_IDLE: begin
				cmd.wr_a    = accept && (action == ACT_WR_A);
				cmd.wr_b    = accept && (action == ACT_WR_B);
				cmd.clr_acc = 1'b1;
			end
			S_MISM: begin
				cmd.emit_mis = 1'b1;
			end
			S_ISSUE: begin
				cmd.rd_en = 1'b1;
			end
			S_WAIT: begin
				cmd.rd_en = 1'b0;
			end
			S_EMIT: begin
				cmd.emit    = 1'b1;
				cmd.clr_acc = 1'b1;
				cmd.last    = elem_last;
			end
			default: begin
				cmd.clr_acc = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// loop counters: i column of B, j row of A, k inner index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					i_q <= '0;
					j_q <= '0;
					k_q <= '0;
				end
				S_ISSUE: begin
					k_q <= k_last ? '0 : k_q + 1'b1;
				end
				S_EMIT: begin
					k_q <= '0;
					if (j_last) begin
						j_q <= '0;
						i_q <= i_q + 1'b1;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				default: begin
					k_q <= k_q;
				end
			endcase
		end
	end

endmodule

### rtl/imm_dp.sv
// ----------------------------------------------------------------------------
// imm_dp
// Datapath of the matrix multiplier: dimension registers, the A and B
// element stores, the read / multiply / accumulate pipeline and the result
// registers.
// ----------------------------------------------------------------------------
module imm_dp #(
	parameter int MAX_DIM = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  imm_pkg::imm_cmd_t                   cmd,
	output imm_pkg::imm_sts_t                   sts,
	input  logic                                cfg_valid,
	input  logic [imm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [imm_pkg::DIM_W-1:0]           cfg_data,
	input  logic [imm_pkg::IDX_W-1:0]           row,
	input  logic [imm_pkg::IDX_W-1:0]           col,
	input  logic signed [imm_pkg::DATA_W-1:0]   value,
	output logic                                valid,
	output logic [imm_pkg::IDX_W-1:0]           out_row,
	output logic [imm_pkg::IDX_W-1:0]           out_col,
	output logic signed [imm_pkg::DATA_W-1:0]   product,
	output logic                                last,
	output logic                                mismatch
);
	import imm_pkg::*;

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = (MAX_DIM > 1) ? $clog2(DEPTH) : 1;
	localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIM);

	logic [DIM_W-1:0]  a_rows_q, a_cols_q, b_rows_q, b_cols_q;
	logic [DATA_W-1:0] mem_a_q [DEPTH];
	logic [DATA_W-1:0] mem_b_q [DEPTH];
	logic [AW-1:0]     wr_addr, rd_a_addr, rd_b_addr;
	logic              wr_ok;
	logic [DATA_W-1:0] a_s1, b_s1, prod_s2, acc_q;
	logic              vld_s1, vld_s2;
	logic              valid_q, last_q, mismatch_q;
	logic [IDX_W-1:0]  out_row_q, out_col_q;
	logic [DATA_W-1:0] product_q;

	// dimension registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_rows_q <= DIM_RESET;
			a_cols_q <= DIM_RESET;
			b_rows_q <= DIM_RESET;
			b_cols_q <= DIM_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_A_ROWS: a_rows_q <= cfg_data;
				REG_A_COLS: a_cols_q <= cfg_data;
				REG_B_ROWS: b_rows_q <= cfg_data;
				REG_B_COLS: b_cols_q <= cfg_data;
				default:    a_rows_q <= a_rows_q;
			endcase
		end
	end

	// dimensions saturate at the store size
	assign sts.a_rows    = (a_rows_q > DIM_MAX) ? DIM_MAX : a_rows_q;
	assign sts.a_cols    = (a_cols_q > DIM_MAX) ? DIM_MAX : a_cols_q;
	assign sts.b_rows    = (b_rows_q > DIM_MAX) ? DIM_MAX : b_rows_q;
	assign sts.b_cols    = (b_cols_q > DIM_MAX) ? DIM_MAX : b_cols_q;
	assign sts.pipe_busy = vld_s1 || vld_s2;

	assign wr_ok     = (int'(row) < MAX_DIM) && (int'(col) < MAX_DIM);
	assign wr_addr   = AW'(int'(row) * MAX_DIM + int'(col));
	assign rd_a_addr = AW'(int'(cmd.row_idx) * MAX_DIM + int'(cmd.k_idx));
	assign rd_b_addr = AW'(int'(cmd.k_idx) * MAX_DIM + int'(cmd.col_idx));

	// element stores
	always_ff @(posedge clk) begin
		if (cmd.wr_a && wr_ok)
			mem_a_q[wr_addr] <= $unsigned(value);
		if (cmd.rd_en)
			a_s1 <= mem_a_q[rd_a_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_b && wr_ok)
			mem_b_q[wr_addr] <= $unsigned(value);
		if (cmd.rd_en)
			b_s1 <= mem_b_q[rd_b_addr];
	end

	// multiply, low word only
	always_ff @(posedge clk) begin
		prod_s2 <= DATA_W'(a_s1 * b_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= cmd.rd_en;
			vld_s2 <= vld_s1;
		end
	end

	// accumulate, wraps modulo 2^32
	always_ff @(posedge clk) begin
		if (cmd.clr_acc)
			acc_q <= '0;
		else if (vld_s2)
			acc_q <= acc_q + prod_s2;
	end

	// result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= cmd.emit || cmd.emit_mis;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_mis) begin
			out_row_q  <= '0;
			out_col_q  <= '0;
			product_q  <= '0;
			last_q     <= 1'b1;
			mismatch_q <= 1'b1;
		end else if (cmd.emit) begin
			out_row_q  <= cmd.row_idx;
			out_col_q  <= cmd.col_idx;
			product_q  <= acc_q;
			last_q     <= cmd.last;
			mismatch_q <= 1'b0;
		end
	end

	assign valid    = valid_q;
	assign out_row  = out_row_q;
	assign out_col  = out_col_q;
	assign product  = $signed(product_q);
	assign last     = last_q;
	assign mismatch = mismatch_q;

endmodule

### rtl/integer_matrix_multiply.sv
// ----------------------------------------------------------------------------
// integer_matrix_multiply
// Integer matrix multiplier: C = A * B with 32-bit wrapping multiply-accumulate.
//
// Commands enter on start/action/row/col/value and are taken when start is
// high and busy is low. Element writes (A or B) never raise busy, so loads can
// stream one per cycle. A multiply raises busy until its last result has been
// issued.
// Dimensions are written on the cfg_valid/cfg_ready channel (always ready);
// the user must write them only while no command is in progress, which the
// block does not enforce. Values above the store size saturate. Each result
// appears for one cycle with valid high: columns of B outer, rows of A inner,
// last on the final element. Mismatched inner dimensions give one result with
// mismatch and last set, from the mismatch state.
// Each element takes one store read per cycle in the issue state into a single
// multiplier, goes through the read, multiply and accumulate pipeline and
// ends in an emit step once the pipeline has drained; an element with a_cols
// of zero skips the reads and emits zero.
// Reset clears the controller and sets all dimensions to one; store contents
// are undefined until written. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module integer_matrix_multiply #(
	parameter int MAX_DIM = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [imm_pkg::ACT_W-1:0]           action,
	input  logic [imm_pkg::IDX_W-1:0]           row,
	input  logic [imm_pkg::IDX_W-1:0]           col,
	input  logic signed [imm_pkg::DATA_W-1:0]   value,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [imm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [imm_pkg::DIM_W-1:0]           cfg_data,
	output logic                                valid,
	output logic [imm_pkg::IDX_W-1:0]           out_row,
	output logic [imm_pkg::IDX_W-1:0]           out_col,
	output logic signed [imm_pkg::DATA_W-1:0]   product,
	output logic                                last,
	output logic                                mismatch
);
	import imm_pkg::*;

	imm_cmd_t cmd;
	imm_sts_t sts;

	assign cfg_ready = 1'b1;

	imm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (action),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	imm_dp #(
		.MAX_DIM (MAX_DIM)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.row       (row),
		.col       (col),
		.value     (value),
		.valid     (valid),
		.out_row   (out_row),
		.out_col   (out_col),
		.product   (product),
		.last      (last),
		.mismatch  (mismatch)
	);

	a_mis_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid && mismatch |-> last)
		else $error("mismatch result without last");

	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid && last |=> !valid)
		else $error("result right after last");

	a_no_wr_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !cmd.wr_a && !cmd.wr_b)
		else $error("store write while busy");

	a_emit_drained: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !sts.pipe_busy)
		else $error("emit before accumulate pipeline drained");

endmodule

### dv/integer_matrix_multiply_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// integer_matrix_multiply_checker
// Watches the command, dimension and result channels of the matrix multiplier.
// It keeps its own copy of both element stores and the dimensions, computes
// every product element when a multiply transaction is taken, and compares
// each result strobe field by field against the oldest element still due.
// ----------------------------------------------------------------------------
module integer_matrix_multiply_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic                               busy,
	input  logic [imm_pkg::ACT_W-1:0]          action,
	input  logic [imm_pkg::IDX_W-1:0]          row,
	input  logic [imm_pkg::IDX_W-1:0]          col,
	input  logic signed [imm_pkg::DATA_W-1:0]  value,
	input  logic                               cfg_valid,
	input  logic                               cfg_ready,
	input  logic [imm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [imm_pkg::DIM_W-1:0]          cfg_data,
	input  logic                               valid,
	input  logic [imm_pkg::IDX_W-1:0]          out_row,
	input  logic [imm_pkg::IDX_W-1:0]          out_col,
	input  logic signed [imm_pkg::DATA_W-1:0]  product,
	input  logic                               last,
	input  logic                               mismatch,
	output int                                 fail_count,
	output int                                 outstanding
);
	import imm_pkg::*;

	localparam int MAX_DIM = 8;

	typedef struct packed {
		logic [IDX_W-1:0]  row;
		logic [IDX_W-1:0]  col;
		logic [DATA_W-1:0] sum;
		logic              last;
		logic              mismatch;
	} elem_t;

	logic [DATA_W-1:0] store_a [MAX_DIM*MAX_DIM];
	logic [DATA_W-1:0] store_b [MAX_DIM*MAX_DIM];
	logic [DIM_W-1:0]  dims [4];
	elem_t             due_elems [$];
	int                errors = 0;

	initial begin
		fail_count = 0;
		outstanding = 0;
		foreach (store_a[i]) store_a[i] = '0;
		foreach (store_b[i]) store_b[i] = '0;
		foreach (dims[i]) dims[i] = DIM_RESET;
	end

	function automatic int unsigned clip_dim(logic [DIM_W-1:0] d);
		return (d > MAX_DIM) ? MAX_DIM : int'(d);
	endfunction

	// column of b outer, row of a inner
	task automatic multiply_matrices();
		int unsigned n_rows, inner_a, inner_b, n_cols;
		logic [DATA_W-1:0] acc;
		elem_t e;
		n_rows  = clip_dim(dims[REG_A_ROWS]);
		inner_a = clip_dim(dims[REG_A_COLS]);
		inner_b = clip_dim(dims[REG_B_ROWS]);
		n_cols  = clip_dim(dims[REG_B_COLS]);
		if (inner_a != inner_b) begin
			e = '0;
			e.last = 1'b1;
			e.mismatch = 1'b1;
			due_elems.push_back(e);
		end else begin
			for (int i = 0; i < n_cols; i++) begin
				for (int j = 0; j < n_rows; j++) begin
					acc = '0;
					for (int k = 0; k < inner_a; k++)
						acc += store_a[j*MAX_DIM+k] * store_b[k*MAX_DIM+i];
					e.row = IDX_W'(j);
					e.col = IDX_W'(i);
					e.sum = acc;
					e.last = (i == n_cols - 1) && (j == n_rows - 1);
					e.mismatch = 1'b0;
					due_elems.push_back(e);
				end
			end
		end
	endtask

	always @(posedge clk) begin
		elem_t head;
		if (!arst_n) begin
			foreach (dims[i]) dims[i] = DIM_RESET;
			due_elems.delete();
		end else begin
			if (valid) begin
				if (due_elems.size() == 0) begin
					if (errors < 10)
						$display({"%0t: unexpected result row %0d col %0d product %0d",
							" last %0b mismatch %0b"},
							$realtime, out_row, out_col, product, last, mismatch);
					errors++;
				end else begin
					head = due_elems.pop_front();
					if (out_row !== head.row || out_col !== head.col ||
							product !== head.sum || last !== head.last ||
							mismatch !== head.mismatch) begin
						if (errors < 10)
							$display({"%0t: result differs, expected row %0d col %0d",
								" product %0d last %0b mismatch %0b, got row %0d",
								" col %0d product %0d last %0b mismatch %0b"},
								$realtime, head.row, head.col, $signed(head.sum),
								head.last, head.mismatch, out_row, out_col, product,
								last, mismatch);
						errors++;
					end
				end
			end
			if (cfg_valid && cfg_ready)
				dims[cfg_index] = cfg_data;
			if (start && !busy) begin
				case (action)
					ACT_WR_A: store_a[{row, col}] = value;
					ACT_WR_B: store_b[{row, col}] = value;
					ACT_MUL:  multiply_matrices();
					default:  ;
				endcase
			end
		end
		fail_count <= errors;
		outstanding <= due_elems.size();
	end

endmodule

### dv/integer_matrix_multiply_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// integer_matrix_multiply_tb
// Drives element loads, multiply commands and dimension settings into the
// matrix multiplier. A short directed sequence covers value extremes, inner
// dimension mismatch, empty products and ignored commands; random phases then
// pick dimensions (saturating ones included), load operands with random gaps
// and issue multiplies. Checking is done by the checker beside the block.
// ----------------------------------------------------------------------------
module integer_matrix_multiply_tb;
	import imm_pkg::*;

	localparam int MAX_DIM = 8;
	localparam logic [ACT_W-1:0] ACT_NOP = 2'd3;
	localparam int TARGET_ITEMS  = 500;
	localparam int SETTLE_CYCLES = 24;
	localparam int IDLE_LIMIT    = 2000;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     start = 1'b0;
	logic                     busy;
	logic [ACT_W-1:0]         action = ACT_WR_A;
	logic [IDX_W-1:0]         row = '0;
	logic [IDX_W-1:0]         col = '0;
	logic signed [DATA_W-1:0] value = '0;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [CFG_IDX_W-1:0]     cfg_index = REG_A_ROWS;
	logic [DIM_W-1:0]         cfg_data = DIM_RESET;
	logic                     valid;
	logic [IDX_W-1:0]         out_row;
	logic [IDX_W-1:0]         out_col;
	logic signed [DATA_W-1:0] product;
	logic                     last;
	logic                     mismatch;

	int fail_count;
	int outstanding;
	int items_sent = 0;
	int gap_max = 17;
	int idle_cycles = 0;
	bit a_loaded [MAX_DIM*MAX_DIM];
	bit b_loaded [MAX_DIM*MAX_DIM];
	logic [DIM_W-1:0] cur_dim [4] = '{DIM_RESET, DIM_RESET, DIM_RESET, DIM_RESET};
	logic [CFG_IDX_W-1:0] dim_regs [4] = '{REG_A_ROWS, REG_A_COLS, REG_B_ROWS, REG_B_COLS};

	always #5 clk = ~clk;

	integer_matrix_multiply u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.action    (action),
		.row       (row),
		.col       (col),
		.value     (value),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.valid     (valid),
		.out_row   (out_row),
		.out_col   (out_col),
		.product   (product),
		.last      (last),
		.mismatch  (mismatch)
	);

	integer_matrix_multiply_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.action      (action),
		.row         (row),
		.col         (col),
		.value       (value),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.valid       (valid),
		.out_row     (out_row),
		.out_col     (out_col),
		.product     (product),
		.last        (last),
		.mismatch    (mismatch),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || (cfg_valid && cfg_ready) || valid)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic int unsigned span(logic [DIM_W-1:0] d);
		return (d > MAX_DIM) ? MAX_DIM : int'(d);
	endfunction

	function automatic logic [IDX_W-1:0] pick_index(int unsigned limit);
		return (limit == 0) ? IDX_W'($urandom_range(0, MAX_DIM - 1)) :
			IDX_W'($urandom_range(0, limit - 1));
	endfunction

	function automatic logic [DATA_W-1:0] rand_value();
		case ($urandom_range(0, 7))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return '1;
			3: return '0;
			4: return DATA_W'($urandom_range(0, 15)) - DATA_W'(8);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [DIM_W-1:0] pick_dim();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 8)
			return '0;
		else if (sel < 20)
			return DIM_W'($urandom_range(9, 15));
		else if (sel < 45)
			return DIM_W'($urandom_range(5, 8));
		else
			return DIM_W'($urandom_range(1, 4));
	endfunction

	task automatic send(input logic [ACT_W-1:0] act, input logic [IDX_W-1:0] r,
			input logic [IDX_W-1:0] c, input logic [DATA_W-1:0] v);
		int gap;
		gap = $urandom_range(0, gap_max);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		action <= act;
		row <= r;
		col <= c;
		value <= v;
		do @(posedge clk); while (busy);
		if (act != ACT_NOP)
			items_sent++;
		if (act == ACT_WR_A)
			a_loaded[{r, c}] = 1'b1;
		if (act == ACT_WR_B)
			b_loaded[{r, c}] = 1'b1;
	endtask

	// every element a multiply will read must have been loaded
	task automatic load_missing();
		int unsigned an, am, bn, bm;
		an = span(cur_dim[REG_A_ROWS]);
		am = span(cur_dim[REG_A_COLS]);
		bn = span(cur_dim[REG_B_ROWS]);
		bm = span(cur_dim[REG_B_COLS]);
		if (am != bn || an == 0 || bm == 0)
			return;
		for (int j = 0; j < an; j++)
			for (int k = 0; k < am; k++)
				if (!a_loaded[j*MAX_DIM+k])
					send(ACT_WR_A, IDX_W'(j), IDX_W'(k), rand_value());
		for (int k = 0; k < am; k++)
			for (int i = 0; i < bm; i++)
				if (!b_loaded[k*MAX_DIM+i])
					send(ACT_WR_B, IDX_W'(k), IDX_W'(i), rand_value());
	endtask

	task automatic run_multiply();
		load_missing();
		send(ACT_MUL, IDX_W'($urandom), IDX_W'($urandom), $urandom);
	endtask

	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (outstanding != 0 || busy);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic load_dims(input logic [DIM_W-1:0] ar, input logic [DIM_W-1:0] ac,
			input logic [DIM_W-1:0] br, input logic [DIM_W-1:0] bc);
		logic [DIM_W-1:0] vals [4];
		vals = '{ar, ac, br, bc};
		drain();
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= dim_regs[i];
			cfg_data <= vals[i];
			do @(posedge clk); while (!cfg_ready);
			cur_dim[dim_regs[i]] = vals[i];
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic random_phase(input bit full_size);
		int n;
		int sel;
		logic [DIM_W-1:0] ar, ac, br, bc;
		if (full_size) begin
			ar = 4'd15;
			ac = 4'd9;
			br = 4'd8;
			bc = 4'd12;
		end else begin
			ar = pick_dim();
			ac = pick_dim();
			br = ($urandom_range(0, 4) == 0) ? pick_dim() : ac;
			bc = pick_dim();
		end
		load_dims(ar, ac, br, bc);
		gap_max = ($urandom_range(0, 3) == 0) ? 0 : 17;
		n = $urandom_range(4, 30);
		repeat (n) begin
			sel = $urandom_range(0, 99);
			if (sel < 25)
				send(ACT_WR_A, pick_index(span(ar)), pick_index(span(ac)), rand_value());
			else if (sel < 50)
				send(ACT_WR_B, pick_index(span(br)), pick_index(span(bc)), rand_value());
			else if (sel < 58)
				send(($urandom_range(0, 1) == 0) ? ACT_WR_A : ACT_WR_B,
					IDX_W'($urandom), IDX_W'($urandom), rand_value());
			else if (sel < 90)
				run_multiply();
			else
				send(ACT_NOP, IDX_W'($urandom), IDX_W'($urandom), $urandom);
		end
		run_multiply();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single element products at the value extremes
		send(ACT_WR_A, 3'd0, 3'd0, 32'h7fff_ffff);
		send(ACT_WR_B, 3'd0, 3'd0, 32'h7fff_ffff);
		run_multiply();
		send(ACT_WR_A, 3'd0, 3'd0, 32'h8000_0000);
		send(ACT_WR_B, 3'd0, 3'd0, 32'hffff_ffff);
		run_multiply();
		send(ACT_NOP, 3'd7, 3'd7, 32'hffff_ffff);
		run_multiply();

		load_dims(4'd2, 4'd2, 4'd2, 4'd2);
		send(ACT_WR_A, 3'd1, 3'd1, 32'h8000_0000);
		send(ACT_WR_B, 3'd1, 3'd1, 32'h8000_0000);
		run_multiply();

		// inner dimensions disagree
		load_dims(4'd3, 4'd3, 4'd4, 4'd2);
		run_multiply();
		// empty inner sum
		load_dims(4'd2, 4'd0, 4'd0, 4'd3);
		run_multiply();
		// no output elements
		load_dims(4'd0, 4'd1, 4'd1, 4'd4);
		run_multiply();
		load_dims(4'd8, 4'd1, 4'd1, 4'd0);
		run_multiply();

		random_phase(1'b1);
		while (items_sent < TARGET_ITEMS)
			random_phase(1'b0);

		drain();
		if (fail_count == 0 && outstanding == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
